### src/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: byte classes, result types and the
// range check of the decode stage; used by the decode stage, the result queue and the top level.
// Depends on nothing.
package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [CpWidth-1:0] ReplacementReset = 21'h00FFFD;
  localparam logic [CpWidth-1:0] SurrogateLo      = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi      = 21'h00DFFF;
  localparam logic [CpWidth-1:0] MaxScalar        = 21'h10FFFF;

  // Class of a raw byte, taken from its prefix bits.
  typedef enum logic [2:0] {
    CLS_CONT = 3'd0,
    CLS_LEN1 = 3'd1,
    CLS_LEN2 = 3'd2,
    CLS_LEN3 = 3'd3,
    CLS_LEN4 = 3'd4,
    CLS_BAD  = 3'd5
  } byte_class_t;

  // One result as it leaves the decoder.
  typedef struct packed {
    logic [CpWidth-1:0]    code_point;
    logic [CountWidth-1:0] byte_count;
    logic                  malformed;
    logic                  last_result;
  } result_t;

  // Everything one input byte produces: up to two results.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] num;
  } dec_out_t;

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    if (b[7:6] == 2'b10) c = CLS_CONT;
    else if (b[7] == 1'b0) c = CLS_LEN1;
    else if (b[7:5] == 3'b110) c = CLS_LEN2;
    else if (b[7:4] == 4'b1110) c = CLS_LEN3;
    else if (b[7:3] == 5'b11110) c = CLS_LEN4;
    else c = CLS_BAD;
    return c;
  endfunction

  // Shortest-form and scalar-range check for a multi-byte sequence.
  function automatic logic value_ok(input logic [CpWidth-1:0] v,
                                    input logic [CountWidth-1:0] len);
    logic [CpWidth-1:0] lo;
    logic [CpWidth-1:0] hi;
    case (len)
      3'd2: begin
        lo = 21'h000080;
        hi = 21'h0007FF;
      end
      3'd3: begin
        lo = 21'h000800;
        hi = 21'h00FFFF;
      end
      default: begin
        lo = 21'h010000;
        hi = MaxScalar;
      end
    endcase
    return (v >= lo) && (v <= hi) && !((v >= SurrogateLo) && (v <= SurrogateHi));
  endfunction

endpackage

### src/utf8d_decode.sv
// Decode stage of the UTF-8 stream decoder: sequence state registers and the
// single-pass logic that turns one byte into zero, one or two results.
// Depends on utf8d_pkg.
module utf8d_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [7:0]                          byte_value,
  input  logic                                final_byte,
  input  logic [utf8d_pkg::CpWidth-1:0]       replacement_code,
  output utf8d_pkg::dec_out_t                 dec
);
  import utf8d_pkg::*;

  logic [CpWidth-1:0]    partial_value;
  logic [CountWidth-1:0] expected_length;
  logic [CountWidth-1:0] bytes_seen;
  logic [CpWidth-1:0]    partial_value_next;
  logic [CountWidth-1:0] expected_length_next;
  logic [CountWidth-1:0] bytes_seen_next;

  byte_class_t           cls;
  result_t               idle_res;
  logic                  idle_emit;
  logic [CpWidth-1:0]    idle_pv;
  logic [CountWidth-1:0] idle_len;
  logic [CountWidth-1:0] idle_bs;
  logic [CpWidth-1:0]    pv_ext;
  logic [CountWidth-1:0] bs_inc;

  assign cls    = byte_class(byte_value);
  assign pv_ext = {partial_value[CpWidth-7:0], byte_value[5:0]};
  assign bs_inc = bytes_seen + 3'd1;

  // Handling of a byte when no sequence is open (state is all zero then).
  always_comb begin
    idle_res  = '{code_point: replacement_code, byte_count: 3'd1,
                  malformed: 1'b1, last_result: 1'b0};
    idle_emit = 1'b1;
    idle_pv   = '0;
    idle_len  = '0;
    idle_bs   = '0;
    unique case (cls) inside
      CLS_LEN1: begin
        idle_res.code_point = {14'd0, byte_value[6:0]};
        idle_res.malformed  = 1'b0;
      end
      CLS_LEN2, CLS_LEN3, CLS_LEN4: begin
        if (final_byte) begin
          idle_res.byte_count = 3'd0;
        end else begin
          idle_emit = 1'b0;
          idle_len  = cls;
          idle_bs   = 3'd1;
          if (cls == CLS_LEN2) idle_pv = {16'd0, byte_value[4:0]};
          else if (cls == CLS_LEN3) idle_pv = {17'd0, byte_value[3:0]};
          else idle_pv = {18'd0, byte_value[2:0]};
        end
      end
      default: begin
        // Stray continuation byte or an invalid lead byte.
      end
    endcase
  end

  always_comb begin
    dec                  = '0;
    partial_value_next   = '0;
    expected_length_next = '0;
    bytes_seen_next      = '0;
    if (expected_length == 3'd0) begin
      dec.res0             = idle_res;
      dec.num              = {1'b0, idle_emit};
      partial_value_next   = idle_pv;
      expected_length_next = idle_len;
      bytes_seen_next      = idle_bs;
    end else if (cls == CLS_CONT) begin
      if (bs_inc >= expected_length) begin
        dec.num = 2'd1;
        if (value_ok(pv_ext, expected_length)) begin
          dec.res0 = '{code_point: pv_ext, byte_count: expected_length,
                       malformed: 1'b0, last_result: 1'b0};
        end else begin
          dec.res0 = '{code_point: replacement_code, byte_count: expected_length,
                       malformed: 1'b1, last_result: 1'b0};
        end
      end else if (final_byte) begin
        dec.num  = 2'd1;
        dec.res0 = '{code_point: replacement_code, byte_count: 3'd0,
                     malformed: 1'b1, last_result: 1'b0};
      end else begin
        partial_value_next   = pv_ext;
        expected_length_next = expected_length;
        bytes_seen_next      = bs_inc;
      end
    end else begin
      // A non-continuation byte cuts the open sequence short, then starts afresh.
      dec.res0 = '{code_point: replacement_code, byte_count: bytes_seen,
                   malformed: 1'b1, last_result: 1'b0};
      dec.res1             = idle_res;
      dec.num              = idle_emit ? 2'd2 : 2'd1;
      partial_value_next   = idle_pv;
      expected_length_next = idle_len;
      bytes_seen_next      = idle_bs;
    end
    if (dec.num == 2'd1) dec.res0.last_result = 1'b1;
    if (dec.num == 2'd2) dec.res1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      expected_length <= '0;
      bytes_seen      <= '0;
    end else if (accept) begin
      partial_value   <= partial_value_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
    end
  end

endmodule

### src/utf8d_result_queue.sv
// Result queue of the UTF-8 stream decoder: a small register queue that takes
// up to two results per cycle and hands out one while out_ready is high. Depends on utf8d_pkg.
module utf8d_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utf8d_pkg::dec_out_t dec,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output utf8d_pkg::result_t  out_res
);
  import utf8d_pkg::*;

  result_t              entries [QueueDepth];
  logic [QueuePtrW-1:0] head;
  logic [QueuePtrW-1:0] tail;
  logic [QueuePtrW:0]   count;
  logic [QueuePtrW-1:0] tail_plus1;
  logic [1:0]           push_num;
  logic                 pop;

  assign tail_plus1 = tail + 1'b1;
  assign push_num   = push ? dec.num : 2'd0;
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_res    = entries[head];
  // Room for the worst case of two results from the next byte.
  assign space_ok   = (count <= (QueuePtrW+1)'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) entries[tail] <= dec.res0;
    if (push_num == 2'd2) entries[tail_plus1] <= dec.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QueuePtrW'(push_num);
      if (pop) head <= head + 1'b1;
      count <= count + (QueuePtrW+1)'(push_num) - (QueuePtrW+1)'(pop);
    end
  end

endmodule

### src/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level. The results of an accepted byte are written
// into the registered result queue, from which they are taken. Throughput: one
// byte per cycle; the decode logic handles each byte in a single pass and the
// rate is set by the four-entry result queue, which holds input off while fewer
// than two entries are free. Reset (rst, synchronous) closes any open sequence,
// empties the queue and sets the replacement code to U+FFFD. Depends on utf8d_pkg.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  // Configuration: replacement code point, written when cfg_we is high.
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  // Input bytes.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // final_byte
  // Decoded results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] byte_count
  output logic        m_tuser,   // malformed
  output logic        m_tlast    // last_result
);
  import utf8d_pkg::*;

  logic [CpWidth-1:0] replacement_code;
  logic               accept;
  dec_out_t           dec;
  result_t            out_res;

  // The user is to change the replacement code only while the decoder is idle;
  // the block itself does not enforce this. It feeds the decode logic directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_code <= ReplacementReset;
    end else if (cfg_we) begin
      replacement_code <= cfg_wdata;
    end
  end

  // A byte transaction completes when the queue has room for two results, so
  // no byte is ever held back half-decoded.
  assign accept = s_tvalid && s_tready;

  utf8d_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .byte_value       (s_tdata),
    .final_byte       (s_tlast),
    .replacement_code (replacement_code),
    .dec              (dec)
  );

  // The queue decouples the two sides: bytes keep flowing while results wait
  // to be taken, as long as two entries are free.
  utf8d_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .dec       (dec),
    .space_ok  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.byte_count, out_res.code_point};
  assign m_tuser = out_res.malformed;
  assign m_tlast = out_res.last_result;

  // Input is only held off while results are waiting in the queue.
  a_stall_needs_results: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with an empty result queue");

  // The queue comes out of reset empty.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");

  // A well-formed result always consumed at least one byte.
  a_good_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[23:21] != 3'd0))
    else $error("well-formed result with a byte count of zero");

  // A sequence cut off at the final byte is the last result of its byte.
  a_cutoff_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[23:21] == 3'd0)) |-> (m_tuser && m_tlast))
    else $error("cut-off result not marked malformed and last");

endmodule
